@@ sv/adjacency_matrix_graph_store_assert.svh @@
// Assertion macros for the adjacency matrix graph store checker.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH

// Plain property, checked on every clock edge outside reset.
`define AMGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define AMGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AMGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/amgs_pkg.sv @@
// Shared types and constants for the adjacency matrix graph store.
`timescale 1ns / 1ps
package amgs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int LABEL_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_EDGE  = 2'd0,
    FN_LIST_SUCC = 2'd1,
    FN_LIST_PRED = 2'd2,
    FN_LIST_ALL  = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CK,
    S_DECIDE,
    S_WR_A,
    S_WR_B,
    S_ROW_RD,
    S_ROW_WR,
    S_EMIT_ADD,
    S_SUCC_RD,
    S_SUCC_LD,
    S_LST_RD,
    S_LST_CK,
    S_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic lab_rd;
    logic find_check;
    logic wr_a;
    logic wr_b;
    logic adj_rd;
    logic adj_at_j;
    logic row_wr;
    logic succ_load;
    logic j_clear;
    logic lst_step;
    logic emit_add;
    logic emit_final;
  } amgs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  in_fire;
    func_t func;
    logic  scan_done;
    logic  found_a;
    logic  found_b;
    logic  same;
    logic  full;
    logic  hit;
    logic  pending;
    logic  out_free;
  } amgs_sts_t;

endpackage

@@ sv/amgs_in_if.sv @@
// Request channel: one operation per transaction.
`timescale 1ns / 1ps
interface amgs_in_if import amgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [LABEL_W-1:0] first_vertex;
  logic signed [LABEL_W-1:0] second_vertex;

  modport source (output valid, func, first_vertex, second_vertex, input ready);
  modport sink   (input valid, func, first_vertex, second_vertex, output ready);
endinterface

@@ sv/amgs_out_if.sv @@
// Response channel: one result per transaction.
`timescale 1ns / 1ps
interface amgs_out_if import amgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LABEL_W-1:0] neighbor;
  logic                      last;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        vertex_count;

  modport source (output valid, neighbor, last, status, vertex_count, input ready);
  modport sink   (input valid, neighbor, last, status, vertex_count, output ready);
endinterface

@@ sv/adjacency_matrix_graph_store.sv @@
// Top level of the adjacency matrix graph store.
`timescale 1ns / 1ps
// Directed graph store. Each request transaction carries func, first_vertex and
// second_vertex; the response channel returns one or more results per request,
// the final one flagged by last. Labels get dense slots in order of first use;
// edges live in a MAX_VERTICES x MAX_VERTICES bit matrix held in RAM.
// Every operation first scans the label RAM slot by slot (registered read,
// then compare). An add edge then gives a single result; a list query walks
// the slots once more unless its vertex is unknown, and its results stream
// out while the walk continues, one entry held back so the last can be marked.
// One request is handled at a time; request.ready is high only while the
// sequencer is idle, including while the final result still waits in the
// output register.
// Reset (synchronous, rst high) empties the store: the vertex count clears
// and per-row valid bits mark every matrix row as zero, so no clearing pass
// is run. When response.ready is low the output register holds its result
// and the walk pauses at the next hit that must push the held entry out.
module adjacency_matrix_graph_store import amgs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  amgs_in_if.sink    request,
  amgs_out_if.source response
);

  amgs_cmd_t cmd;
  amgs_sts_t sts;

  amgs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  amgs_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .request  (request),
    .response (response)
  );

endmodule

@@ sv/amgs_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module amgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/amgs_ctrl.sv @@
// Sequencer for the graph store: lookup scan, insert, row update and list walks.
`timescale 1ns / 1ps
module amgs_ctrl import amgs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  amgs_sts_t sts,
  output amgs_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.in_fire) state_next = S_FIND_RD;
      end
      S_FIND_RD: begin
        state_next = sts.scan_done ? S_DECIDE : S_FIND_CK;
      end
      S_FIND_CK: state_next = S_FIND_RD;
      S_DECIDE: begin
        case (sts.func)
          FN_ADD_EDGE: begin
            if (sts.full)          state_next = S_EMIT_ADD;
            else if (!sts.found_a) state_next = S_WR_A;
            else if (!sts.found_b) state_next = S_WR_B;
            else                   state_next = S_ROW_RD;
          end
          FN_LIST_SUCC: state_next = sts.found_a ? S_SUCC_RD : S_FINAL;
          FN_LIST_PRED: state_next = sts.found_a ? S_LST_RD : S_FINAL;
          default:      state_next = S_LST_RD;
        endcase
      end
      S_WR_A: begin
        // a self loop registers the vertex once
        state_next = (!sts.found_b && !sts.same) ? S_WR_B : S_ROW_RD;
      end
      S_WR_B:     state_next = S_ROW_RD;
      S_ROW_RD:   state_next = S_ROW_WR;
      S_ROW_WR:   state_next = S_EMIT_ADD;
      S_EMIT_ADD: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_SUCC_RD:  state_next = S_SUCC_LD;
      S_SUCC_LD:  state_next = S_LST_RD;
      S_LST_RD: begin
        state_next = sts.scan_done ? S_FINAL : S_LST_CK;
      end
      S_LST_CK: begin
        if (!(sts.hit && sts.pending && !sts.out_free)) state_next = S_LST_RD;
      end
      S_FINAL: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:     cmd.accept = 1'b1;
      S_FIND_RD:  cmd.lab_rd = !sts.scan_done;
      S_FIND_CK:  cmd.find_check = 1'b1;
      S_DECIDE:   cmd.j_clear = 1'b1;
      S_WR_A:     cmd.wr_a = 1'b1;
      S_WR_B:     cmd.wr_b = 1'b1;
      S_ROW_RD:   cmd.adj_rd = 1'b1;
      S_ROW_WR:   cmd.row_wr = 1'b1;
      S_EMIT_ADD: cmd.emit_add = sts.out_free;
      S_SUCC_RD:  cmd.adj_rd = 1'b1;
      S_SUCC_LD:  cmd.succ_load = 1'b1;
      S_LST_RD: begin
        cmd.lab_rd   = !sts.scan_done;
        cmd.adj_rd   = !sts.scan_done;
        cmd.adj_at_j = 1'b1;
      end
      S_LST_CK: begin
        // a hit pushes the held entry out, so it needs the output register
        cmd.lst_step = !(sts.hit && sts.pending && !sts.out_free);
      end
      S_FINAL:    cmd.emit_final = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ sv/amgs_dp.sv @@
// Datapath: label and adjacency RAMs, scan counter, pending entry, output register.
`timescale 1ns / 1ps
module amgs_dp import amgs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  amgs_cmd_t cmd,
  output amgs_sts_t sts,
  amgs_in_if.sink   request,
  amgs_out_if.source response
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  func_t                     func;
  logic signed [LABEL_W-1:0] first_vertex;
  logic signed [LABEL_W-1:0] second_vertex;
  logic [CW-1:0]             used;
  logic [CW-1:0]             j;
  logic [IW-1:0]             sa;
  logic [IW-1:0]             sb;
  logic                      found_a;
  logic                      found_b;
  logic                      pending;
  logic signed [LABEL_W-1:0] pend_label;
  logic [MAX_VERTICES-1:0]   succ_row;
  logic [MAX_VERTICES-1:0]   row_valid;

  logic                      out_valid;
  logic signed [LABEL_W-1:0] out_neighbor;
  logic                      out_last;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;

  logic                      in_fire;
  logic                      out_free;
  logic [IW-1:0]             jx;
  logic [IW-1:0]             used_x;
  logic signed [LABEL_W-1:0] lab_q;
  logic [MAX_VERTICES-1:0]   adj_q;
  logic [MAX_VERTICES-1:0]   row_base;
  logic [MAX_VERTICES-1:0]   row_wdata;
  logic [IW-1:0]             adj_raddr;
  logic [1:0]                need;
  logic                      full;
  logic                      hit;
  logic                      same;
  logic                      push_pending;

  assign in_fire  = request.valid && cmd.accept;
  assign out_free = !out_valid || response.ready;
  assign jx       = j[IW-1:0];
  assign used_x   = used[IW-1:0];
  assign same     = (first_vertex == second_vertex);

  // new slots needed by an add; a self loop counts once
  assign need = {1'b0, !found_a} + {1'b0, (!found_b && !(!found_a && same))};
  assign full = ({1'b0, used} + (CW+1)'(need)) > (CW+1)'(MAX_VERTICES);

  assign row_base  = row_valid[sa] ? adj_q : '0;
  assign row_wdata = row_base | ((MAX_VERTICES)'(1) << sb);
  assign adj_raddr = cmd.adj_at_j ? jx : sa;

  always_comb begin
    case (func)
      FN_LIST_ALL:  hit = 1'b1;
      FN_LIST_SUCC: hit = succ_row[jx];
      FN_LIST_PRED: hit = row_valid[jx] && adj_q[sa];
      default:      hit = 1'b0;
    endcase
  end

  assign push_pending = cmd.lst_step && hit && pending;

  amgs_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VERTICES)) u_label_ram (
    .clk   (clk),
    .we    (cmd.wr_a || cmd.wr_b),
    .waddr (used_x),
    .wdata (cmd.wr_b ? second_vertex : first_vertex),
    .re    (cmd.lab_rd),
    .raddr (jx),
    .rdata (lab_q)
  );

  amgs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (cmd.row_wr),
    .waddr (sa),
    .wdata (row_wdata),
    .re    (cmd.adj_rd),
    .raddr (adj_raddr),
    .rdata (adj_q)
  );

  // operands of the current transaction, successor row and held entry label
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func          <= func_t'(request.func);
      first_vertex  <= request.first_vertex;
      second_vertex <= request.second_vertex;
    end
    if (cmd.succ_load) begin
      succ_row <= row_base;
    end
    if (cmd.lst_step && hit) begin
      pend_label <= lab_q;
    end
  end

  // slot lookup and registration, scan counter, pending flag and row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      j         <= '0;
      found_a   <= 1'b0;
      found_b   <= 1'b0;
      pending   <= 1'b0;
      row_valid <= '0;
      sa        <= '0;
      sb        <= '0;
    end else begin
      if (in_fire || cmd.j_clear) begin
        j <= '0;
      end else if (cmd.find_check || cmd.lst_step) begin
        j <= j + 1'b1;
      end
      if (in_fire) begin
        found_a <= 1'b0;
        found_b <= 1'b0;
        pending <= 1'b0;
      end
      if (cmd.find_check) begin
        if (!found_a && lab_q == first_vertex) begin
          found_a <= 1'b1;
          sa      <= jx;
        end
        if (!found_b && lab_q == second_vertex) begin
          found_b <= 1'b1;
          sb      <= jx;
        end
      end
      if (cmd.wr_a) begin
        found_a <= 1'b1;
        sa      <= used_x;
        if (same) begin
          found_b <= 1'b1;
          sb      <= used_x;
        end
        used <= used + 1'b1;
      end
      if (cmd.wr_b) begin
        found_b <= 1'b1;
        sb      <= used_x;
        used    <= used + 1'b1;
      end
      if (cmd.row_wr) begin
        row_valid[sa] <= 1'b1;
      end
      if (cmd.lst_step && hit) begin
        pending <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_add || cmd.emit_final || push_pending) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_add) begin
      out_neighbor <= '0;
      out_last     <= 1'b1;
      out_status   <= full ? ST_FULL : ST_OK;
      out_count    <= COUNT_W'(used);
    end else if (cmd.emit_final) begin
      out_neighbor <= pending ? pend_label : '0;
      out_last     <= 1'b1;
      out_status   <= pending ? ST_OK : ST_EMPTY;
      out_count    <= COUNT_W'(used);
    end else if (push_pending) begin
      out_neighbor <= pend_label;
      out_last     <= 1'b0;
      out_status   <= ST_OK;
      out_count    <= COUNT_W'(used);
    end
  end

  assign request.ready         = cmd.accept;
  assign response.valid        = out_valid;
  assign response.neighbor     = out_neighbor;
  assign response.last         = out_last;
  assign response.status       = out_status;
  assign response.vertex_count = out_count;

  always_comb begin
    sts           = '0;
    sts.in_fire   = in_fire;
    sts.func      = func;
    sts.scan_done = (j == used);
    sts.found_a   = found_a;
    sts.found_b   = found_b;
    sts.same      = same;
    sts.full      = full;
    sts.hit       = hit;
    sts.pending   = pending;
    sts.out_free  = out_free;
  end

endmodule

@@ sv/amgs_chk.sv @@
// Port-level checker for the adjacency matrix graph store, with its bind.
`timescale 1ns / 1ps
`include "adjacency_matrix_graph_store_assert.svh"
module amgs_chk import amgs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [LABEL_W-1:0]  rsp_neighbor,
  input logic                rsp_last,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [COUNT_W-1:0]  rsp_count
);

  logic [COUNT_W-1:0] seen_count;

  // vertex count of the last completed response transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (rsp_valid && rsp_ready) begin
      seen_count <= rsp_count;
    end
  end

  `AMGS_ASSERT_IMPL(a_count_bound, rsp_valid, rsp_count <= COUNT_W'(MAX_VERTICES), "vertex count above capacity")
  `AMGS_ASSERT_IMPL(a_count_mono, rsp_valid && rsp_ready, rsp_count >= seen_count, "vertex count went down")
  `AMGS_ASSERT_IMPL(a_err_single, rsp_valid && rsp_status != ST_OK, rsp_last && rsp_neighbor == '0, "empty or full result not a lone zero result")
  `AMGS_ASSERT_IMPL(a_status_code, rsp_valid, rsp_status == ST_OK || rsp_status == ST_EMPTY || rsp_status == ST_FULL, "undefined status code")
  `AMGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_neighbor) && $stable(rsp_last) && $stable(rsp_status) && $stable(rsp_count), "stalled response changed")

endmodule

bind adjacency_matrix_graph_store amgs_chk #(.MAX_VERTICES(MAX_VERTICES)) u_chk (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (response.valid),
  .rsp_ready    (response.ready),
  .rsp_neighbor (response.neighbor),
  .rsp_last     (response.last),
  .rsp_status   (response.status),
  .rsp_count    (response.vertex_count)
);
